[design/psfoc_pkg.sv]
// Package for the first-order pressure/temperature compensation block.
// Holds field widths, calibration register indexes and arithmetic constants.
// No dependencies.
`default_nettype none

package psfoc_pkg;

  // Field widths
  localparam int unsigned RAW_W   = 24;  // D1, D2
  localparam int unsigned CAL_W   = 16;  // C1..C6
  localparam int unsigned TEMP_W  = 19;  // TEMP output
  localparam int unsigned PRES_W  = 32;  // P output
  localparam int unsigned SCALE_W = 19;  // P / 10000 output

  localparam int unsigned CAL_COUNT = 6;
  localparam int unsigned CAL_IDX_W = 3;

  // Calibration register indexes
  typedef enum logic [CAL_IDX_W-1:0] {
    REG_C1 = 3'd0,  // pressure sensitivity
    REG_C2 = 3'd1,  // pressure offset
    REG_C3 = 3'd2,  // temp coefficient of sensitivity
    REG_C4 = 3'd3,  // temp coefficient of offset
    REG_C5 = 3'd4,  // reference temperature
    REG_C6 = 3'd5   // temp coefficient of temperature
  } cal_idx_e;

  // Temperature base in hundredths of a degree
  localparam int TEMP_BASE = 2000;

  // Unsigned divide by 10000 for 32-bit operands: (x * DIV_MAGIC) >> DIV_SHIFT
  localparam logic [31:0] DIV_MAGIC = 32'd3518437209;
  localparam int unsigned DIV_SHIFT = 45;
  localparam int          DIV_CONST = 10000;

endpackage : psfoc_pkg

`default_nettype wire

[design/pressure_sensor_first_order_compensation_top.sv]
// First-order pressure/temperature compensation, fully pipelined datapath.
// Depends on psfoc_pkg (widths, register indexes, divider constants).
// Single module: config registers plus a ten-stage arithmetic pipeline.
//
// Usage:
//   Calibration words C1..C6 are loaded through cfg_we_i / cfg_idx_i /
//   cfg_wdata_i, one register per cycle, indexes 0..5; other indexes are
//   ignored. Load them while no request is in flight.
//   A request (raw_pressure_i, raw_temperature_i) is taken on every clock
//   edge with start_i high; busy_o is always low, so one request can enter
//   each cycle.
//   Each request produces one result on temperature_centi_o, pressure_value_o
//   and pressure_scaled_o, marked by done_o for one cycle. Results come out in
//   request order.
//   Throughput is one request per cycle; the result passes through ten register
//   stages: dT, three calibration multiplies, TEMP/OFF/SENS, split D1*SENS
//   partial products, their sum, two truncating shifts, the abs value, a
//   reciprocal multiply for the divide by 10000 and the signed quotient.
//   Reset clears the calibration words to zero and drops all in-flight
//   requests. The receiver has no back-pressure: results must be taken
//   in the cycle done_o is high.
`default_nettype none

module pressure_sensor_first_order_compensation_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Request channel
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic [psfoc_pkg::RAW_W-1:0]         raw_pressure_i,
  input  wire logic [psfoc_pkg::RAW_W-1:0]         raw_temperature_i,
  // Config write port
  input  wire logic                                cfg_we_i,
  input  wire logic [psfoc_pkg::CAL_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [psfoc_pkg::CAL_W-1:0]         cfg_wdata_i,
  // Result channel
  output logic                                     done_o,
  output logic signed [psfoc_pkg::TEMP_W-1:0]      temperature_centi_o,
  output logic signed [psfoc_pkg::PRES_W-1:0]      pressure_value_o,
  output logic signed [psfoc_pkg::SCALE_W-1:0]     pressure_scaled_o
);
  import psfoc_pkg::*;

  localparam int unsigned NSTAGE = 10;
  localparam int unsigned DT_W   = 25;  // D2 - C5*256
  localparam int unsigned MUL_W  = 42;  // dT * Cx
  localparam int unsigned OFF_W  = 37;
  localparam int unsigned SENS_W = 36;
  localparam int unsigned SLO_W  = 18;  // low slice of SENS
  localparam int unsigned SHI_W  = SENS_W - SLO_W;
  localparam int unsigned PLO_W  = RAW_W + SLO_W;
  localparam int unsigned PHI_W  = RAW_W + 1 + SHI_W;
  localparam int unsigned PROD_W = PHI_W + SLO_W;
  localparam int unsigned X_W    = 40;  // D1*SENS/2^21 - OFF

  // ---------------------------------------------------------------
  // Calibration registers
  logic [CAL_W-1:0] cal_q [CAL_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CAL_COUNT; i++) begin
        cal_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < CAL_IDX_W'(CAL_COUNT))) begin
      cal_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // No back-pressure: a request can enter every cycle
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------
  // Valid line, one bit per stage
  logic [NSTAGE-1:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[NSTAGE-2:0], start_i & ~busy_o};
    end
  end

  assign done_o = v_q[NSTAGE-1];

  // ---------------------------------------------------------------
  // Stage 1: dT = D2 - C5*256
  logic signed [DT_W-1:0]  dt_d, dt_q;
  logic [RAW_W-1:0]        d1_1_q, d1_2_q, d1_3_q;

  assign dt_d = $signed({1'b0, raw_temperature_i}) - $signed({1'b0, cal_q[REG_C5], 8'b0});

  // Stage 2: dT products
  logic signed [MUL_W-1:0] tmul_d, omul_d, smul_d;
  logic signed [MUL_W-1:0] tmul_q, omul_q, smul_q;

  assign tmul_d = dt_q * $signed({1'b0, cal_q[REG_C6]});
  assign omul_d = dt_q * $signed({1'b0, cal_q[REG_C4]});
  assign smul_d = dt_q * $signed({1'b0, cal_q[REG_C3]});

  // Stage 3: TEMP, OFF, SENS with truncation toward zero
  logic signed [MUL_W-1:0]  tadj, oadj, sadj;
  logic signed [MUL_W-1:0]  temp_full, off_full, sens_full;
  logic signed [TEMP_W-1:0] temp3_q, temp4_q, temp5_q, temp6_q, temp7_q, temp8_q, temp9_q;
  logic signed [OFF_W-1:0]  off3_q, off4_q, off5_q;
  logic signed [SENS_W-1:0] sens_q;

  assign tadj = tmul_q + $signed({{(MUL_W-23){1'b0}}, {23{tmul_q[MUL_W-1]}}});
  assign oadj = omul_q + $signed({{(MUL_W-6){1'b0}}, {6{omul_q[MUL_W-1]}}});
  assign sadj = smul_q + $signed({{(MUL_W-7){1'b0}}, {7{smul_q[MUL_W-1]}}});

  assign temp_full = (tadj >>> 23) + MUL_W'(TEMP_BASE);
  assign off_full  = $signed({{(MUL_W-CAL_W-17){1'b0}}, cal_q[REG_C2], 17'b0}) + (oadj >>> 6);
  assign sens_full = $signed({{(MUL_W-CAL_W-16){1'b0}}, cal_q[REG_C1], 16'b0}) + (sadj >>> 7);

  // Stage 4: D1 * SENS as two partial products
  logic [PLO_W-1:0]         pp_lo_d, pp_lo_q;
  logic signed [PHI_W-1:0]  pp_hi_d, pp_hi_q;

  assign pp_lo_d = PLO_W'(d1_3_q) * PLO_W'(sens_q[SLO_W-1:0]);
  assign pp_hi_d = $signed({1'b0, d1_3_q}) * $signed(sens_q[SENS_W-1:SLO_W]);

  // Stage 5: recombine partial products
  logic signed [PROD_W-1:0] prod_d, prod_q;

  assign prod_d = $signed({pp_hi_q, {SLO_W{1'b0}}}) +
                  $signed({{(PROD_W-PLO_W){1'b0}}, pp_lo_q});

  // Stage 6: X = trunc(prod / 2^21) - OFF
  logic signed [PROD_W-1:0] padj, x_full;
  logic signed [X_W-1:0]    x_q;

  assign padj   = prod_q + $signed({{(PROD_W-21){1'b0}}, {21{prod_q[PROD_W-1]}}});
  assign x_full = (padj >>> 21) - off5_q;

  // Stage 7: P = trunc(X / 2^15), low 32 bits
  logic signed [X_W-1:0]    xadj, p_full;
  logic signed [PRES_W-1:0] p7_q, p8_q, p9_q;

  assign xadj   = x_q + $signed({{(X_W-15){1'b0}}, {15{x_q[X_W-1]}}});
  assign p_full = xadj >>> 15;

  // Stage 8: magnitude of P for the unsigned divide
  logic [PRES_W-1:0] pabs_d, pabs_q;

  assign pabs_d = p7_q[PRES_W-1] ? (~p7_q + 1'b1) : p7_q;

  // Stage 9: reciprocal multiply
  logic [2*PRES_W-1:0] recip_d, recip_q;

  assign recip_d = (2*PRES_W)'(pabs_q) * (2*PRES_W)'(DIV_MAGIC);

  // Stage 10: quotient with sign restored
  logic [SCALE_W-1:0] quot;
  logic [SCALE_W-1:0] scaled_d;

  assign quot     = recip_q[DIV_SHIFT +: SCALE_W];
  assign scaled_d = p9_q[PRES_W-1] ? (~quot + 1'b1) : quot;

  // ---------------------------------------------------------------
  // Datapath registers, no reset
  always_ff @(posedge clk_i) begin
    // stage 1
    dt_q    <= dt_d;
    d1_1_q  <= raw_pressure_i;
    // stage 2
    tmul_q  <= tmul_d;
    omul_q  <= omul_d;
    smul_q  <= smul_d;
    d1_2_q  <= d1_1_q;
    // stage 3
    temp3_q <= temp_full[TEMP_W-1:0];
    off3_q  <= off_full[OFF_W-1:0];
    sens_q  <= sens_full[SENS_W-1:0];
    d1_3_q  <= d1_2_q;
    // stage 4
    pp_lo_q <= pp_lo_d;
    pp_hi_q <= pp_hi_d;
    temp4_q <= temp3_q;
    off4_q  <= off3_q;
    // stage 5
    prod_q  <= prod_d;
    temp5_q <= temp4_q;
    off5_q  <= off4_q;
    // stage 6
    x_q     <= x_full[X_W-1:0];
    temp6_q <= temp5_q;
    // stage 7
    p7_q    <= p_full[PRES_W-1:0];
    temp7_q <= temp6_q;
    // stage 8
    pabs_q  <= pabs_d;
    p8_q    <= p7_q;
    temp8_q <= temp7_q;
    // stage 9
    recip_q <= recip_d;
    p9_q    <= p8_q;
    temp9_q <= temp8_q;
    // stage 10: output registers
    temperature_centi_o <= temp9_q;
    pressure_value_o    <= p9_q;
    pressure_scaled_o   <= $signed(scaled_d);
  end

  // ---------------------------------------------------------------
  // Assertions
  logic signed [63:0] chk_rem;

  assign chk_rem = 64'(pressure_value_o) - 64'(pressure_scaled_o) * 64'sd10000;

  // divide by 10000 leaves a remainder smaller than the divisor
  a_scaled_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (chk_rem > -64'sd10000) && (chk_rem < 64'sd10000))
    else $error("pressure_scaled remainder out of range");

  // truncation toward zero: remainder takes the sign of the dividend
  a_scaled_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !pressure_value_o[PRES_W-1]) |-> (chk_rem >= 64'sd0))
    else $error("pressure_scaled wrong rounding for positive P");

  a_scaled_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && pressure_value_o[PRES_W-1]) |-> (chk_rem <= 64'sd0))
    else $error("pressure_scaled wrong rounding for negative P");

  // temperature stays within the reachable window
  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (temperature_centi_o >= -19'sd140000) && (temperature_centi_o <= 19'sd140000))
    else $error("temperature_centi out of range");

endmodule : pressure_sensor_first_order_compensation_top

`default_nettype wire

[verif/tb_pressure_sensor_first_order_compensation_top.sv]
// Testbench for the first-order pressure/temperature compensation block.
// Drives raw D1/D2 readings under several calibration sets, predicts TEMP, P and P/10000.
// Depends on psfoc_pkg and pressure_sensor_first_order_compensation_top.
`timescale 1ns / 1ps

module tb_pressure_sensor_first_order_compensation_top;
  import psfoc_pkg::*;

  localparam int                 RAW_MAX        = (1 << RAW_W) - 1;
  localparam int                 CAL_MAX        = (1 << CAL_W) - 1;
  localparam int                 NUM_PHASES     = 11;
  localparam int                 ITEMS_PER_PASS = 153;
  localparam int                 STALL_LIMIT    = 2000;
  localparam int                 DRAIN_CYCLES   = 30;
  // Register indexes past the last calibration word; writes there are dropped
  localparam logic [CAL_IDX_W-1:0] CAL_IDX_SPARE_A = CAL_IDX_W'(CAL_COUNT);
  localparam logic [CAL_IDX_W-1:0] CAL_IDX_SPARE_B = CAL_IDX_W'(CAL_COUNT + 1);

  typedef struct packed {
    logic [RAW_W-1:0] d1;
    logic [RAW_W-1:0] d2;
  } raw_reading_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0]  temp;
    logic signed [PRES_W-1:0]  pres;
    logic signed [SCALE_W-1:0] scaled;
  } comp_reading_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic [RAW_W-1:0]     raw_pressure_i;
  logic [RAW_W-1:0]     raw_temperature_i;
  logic                 cfg_we_i;
  logic [CAL_IDX_W-1:0] cfg_idx_i;
  logic [CAL_W-1:0]     cfg_wdata_i;
  logic                 done_o;
  logic signed [TEMP_W-1:0]  temperature_centi_o;
  logic signed [PRES_W-1:0]  pressure_value_o;
  logic signed [SCALE_W-1:0] pressure_scaled_o;

  // Calibration words as the block should hold them
  logic [CAL_W-1:0] cal_words [CAL_COUNT];

  raw_reading_t  pending_reads [$];
  comp_reading_t compensated_due [$];
  int            mismatch_count;
  bit            gaps_on;
  int            gap_left;
  int            stall_cycles;

  pressure_sensor_first_order_compensation_top DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .raw_pressure_i     (raw_pressure_i),
    .raw_temperature_i  (raw_temperature_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .done_o             (done_o),
    .temperature_centi_o(temperature_centi_o),
    .pressure_value_o   (pressure_value_o),
    .pressure_scaled_o  (pressure_scaled_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // First-order compensation; all signed divides truncate toward zero
  function automatic comp_reading_t compensate(input logic [RAW_W-1:0] d1,
                                               input logic [RAW_W-1:0] d2);
    longint        p1, t2, c1, c2, c3, c4, c5, c6;
    longint        dt, temp, off, sens, p, scaled;
    int            p_low;
    comp_reading_t r;
    p1 = longint'({40'd0, d1});
    t2 = longint'({40'd0, d2});
    c1 = longint'({48'd0, cal_words[REG_C1]});
    c2 = longint'({48'd0, cal_words[REG_C2]});
    c3 = longint'({48'd0, cal_words[REG_C3]});
    c4 = longint'({48'd0, cal_words[REG_C4]});
    c5 = longint'({48'd0, cal_words[REG_C5]});
    c6 = longint'({48'd0, cal_words[REG_C6]});
    dt   = t2 - c5 * 256;
    temp = TEMP_BASE + (dt * c6) / 64'sd8388608;       // / 2^23
    off  = c2 * 131072 + (c4 * dt) / 64'sd64;           // C2*2^17 + C4*dT/2^6
    sens = c1 * 65536 + (c3 * dt) / 64'sd128;           // C1*2^16 + C3*dT/2^7
    p    = ((p1 * sens) / 64'sd2097152 - off) / 64'sd32768;
    // P wraps to 32 bits; the scaled value comes from the wrapped word
    p_low  = int'(p[31:0]);
    scaled = longint'(p_low) / DIV_CONST;
    r.temp   = temp[TEMP_W-1:0];
    r.pres   = p[PRES_W-1:0];
    r.scaled = scaled[SCALE_W-1:0];
    return r;
  endfunction

  // Request driver: takes pending readings, inserts idle bursts when allowed
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (start_i && !busy_o)
        compensated_due.push_back(compensate(raw_pressure_i, raw_temperature_i));
      if (start_i && busy_o) begin
        // hold the request until it is taken
      end else if (gap_left > 0) begin
        start_i  <= 1'b0;
        gap_left = gap_left - 1;
      end else if (pending_reads.size() > 0) begin
        if (gaps_on && $urandom_range(0, 7) == 0) begin
          start_i  <= 1'b0;
          gap_left = $urandom_range(0, 9);
        end else begin
          raw_reading_t rd;
          rd = pending_reads.pop_front();
          start_i           <= 1'b1;
          raw_pressure_i    <= rd.d1;
          raw_temperature_i <= rd.d2;
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (compensated_due.size() == 0) begin
        $error("result with no request outstanding: temp %0d pres %0d scaled %0d",
               temperature_centi_o, pressure_value_o, pressure_scaled_o);
        mismatch_count++;
      end else begin
        comp_reading_t want;
        want = compensated_due.pop_front();
        if (temperature_centi_o !== want.temp) begin
          $error("temperature_centi: expected %0d, got %0d", want.temp, temperature_centi_o);
          mismatch_count++;
        end
        if (pressure_value_o !== want.pres) begin
          $error("pressure_value: expected %0d, got %0d", want.pres, pressure_value_o);
          mismatch_count++;
        end
        if (pressure_scaled_o !== want.scaled) begin
          $error("pressure_scaled: expected %0d, got %0d", want.scaled, pressure_scaled_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no request taken and no result
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_cycles = 0;
    end else if ((start_i && !busy_o) || done_o) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic write_cal(input logic [CAL_IDX_W-1:0] idx, input logic [CAL_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx < CAL_COUNT)
      cal_words[idx] = val;
  endtask

  // Load all six words, plus a write to an unused index that must be dropped
  task automatic load_calibration(input logic [CAL_W-1:0] vals [CAL_COUNT]);
    int order;
    order = $urandom_range(0, 1);
    if (order == 0)
      write_cal($urandom_range(0, 1) ? CAL_IDX_SPARE_A : CAL_IDX_SPARE_B, CAL_W'($urandom));
    for (int i = 0; i < CAL_COUNT; i++)
      write_cal(cal_idx_e'(i), vals[i]);
    if (order == 1)
      write_cal($urandom_range(0, 1) ? CAL_IDX_SPARE_A : CAL_IDX_SPARE_B, CAL_W'($urandom));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do
      @(negedge clk_i);
    while (pending_reads.size() != 0 || start_i || compensated_due.size() != 0);
  endtask

  function automatic logic [CAL_W-1:0] pick_cal_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CAL_W'(CAL_MAX);
      default: return CAL_W'($urandom);
    endcase
  endfunction

  function automatic raw_reading_t pick_reading();
    raw_reading_t rd;
    int           ref_t;
    ref_t = int'({8'd0, cal_words[REG_C5], 8'd0});
    case ($urandom_range(0, 9))
      0:       rd.d1 = '0;
      1:       rd.d1 = RAW_W'(RAW_MAX);
      default: rd.d1 = RAW_W'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       rd.d2 = '0;
      1:       rd.d2 = RAW_W'(RAW_MAX);
      2, 3: begin
        // around the reference temperature, dT small and of either sign
        int t;
        t = ref_t + $urandom_range(0, 600) - 300;
        if (t < 0)       t = 0;
        if (t > RAW_MAX) t = RAW_MAX;
        rd.d2 = RAW_W'(t);
      end
      default: rd.d2 = RAW_W'($urandom);
    endcase
    return rd;
  endfunction

  initial begin
    logic [CAL_W-1:0] cal_set [CAL_COUNT];
    int               ref_t;
    rst_ni            = 1'b0;
    start_i           = 1'b0;
    raw_pressure_i    = '0;
    raw_temperature_i = '0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_wdata_i       = '0;
    mismatch_count    = 0;
    gaps_on           = 1'b1;
    for (int i = 0; i < CAL_COUNT; i++)
      cal_words[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // Calibration set for this pass: typical part, then extremes, then random mixes
      case (phase)
        0:       cal_set = '{16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146};
        1:       cal_set = '{default: '0};
        2:       cal_set = '{default: CAL_W'(CAL_MAX)};
        3: begin
          // largest positive dT
          cal_set = '{default: CAL_W'(CAL_MAX)};
          cal_set[REG_C5] = '0;
        end
        4: begin
          // negative pressure: no sensitivity, full offset
          for (int i = 0; i < CAL_COUNT; i++)
            cal_set[i] = pick_cal_word();
          cal_set[REG_C1] = '0;
          cal_set[REG_C2] = CAL_W'(CAL_MAX);
        end
        default: begin
          for (int i = 0; i < CAL_COUNT; i++)
            cal_set[i] = pick_cal_word();
        end
      endcase
      load_calibration(cal_set);

      @(negedge clk_i);
      gaps_on = (phase != NUM_PHASES - 1) && (phase % 4 != 3);
      if (phase == 0) begin
        ref_t = int'({8'd0, cal_words[REG_C5], 8'd0});
        pending_reads.push_back('{RAW_W'(0), RAW_W'(0)});
        pending_reads.push_back('{RAW_W'(RAW_MAX), RAW_W'(RAW_MAX)});
        pending_reads.push_back('{RAW_W'(0), RAW_W'(RAW_MAX)});
        pending_reads.push_back('{RAW_W'(RAW_MAX), RAW_W'(0)});
        pending_reads.push_back('{24'd4958179, 24'd6815414});
        pending_reads.push_back('{24'hAAAAAA, 24'h555555});
        pending_reads.push_back('{24'h555555, 24'hAAAAAA});
        pending_reads.push_back('{24'h800000, 24'h800000});
        // dT of zero, small positive dT, and small negative dT where truncation toward zero shows
        pending_reads.push_back('{24'd4958179, RAW_W'(ref_t)});
        pending_reads.push_back('{24'd4958179, RAW_W'(ref_t - 1)});
        pending_reads.push_back('{24'd4958179, RAW_W'(ref_t - 63)});
        pending_reads.push_back('{24'd4958179, RAW_W'(ref_t - 127)});
        pending_reads.push_back('{24'd4958179, RAW_W'(ref_t - 129)});
        pending_reads.push_back('{24'd4958179, RAW_W'(ref_t + 1)});
        pending_reads.push_back('{24'd4958179, RAW_W'(ref_t + 129)});
        // low D1: P goes negative, scaled value truncates toward zero; last a high D1
        pending_reads.push_back('{24'd1, RAW_W'(ref_t)});
        pending_reads.push_back('{24'd1000, 24'd6815414});
        pending_reads.push_back('{24'd3000000, RAW_W'(ref_t - 1)});
        pending_reads.push_back('{24'd12345, 24'd100});
        pending_reads.push_back('{24'd16000000, 24'd16000000});
      end else begin
        for (int n = 0; n < ITEMS_PER_PASS; n++)
          pending_reads.push_back(pick_reading());
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
